// ----- src/ile_pkg.sv -----
// Shared types and constants for the indexed list engine.
// No dependencies.
`default_nettype none
package ile_pkg;
  localparam int CAPACITY = 256;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = IDX_W + 1;
  localparam int CMP_W = ((CNT_W > 16) ? CNT_W : 16) + 1;

  typedef enum logic [3:0] {
    OP_APPEND = 4'd0, OP_INSERT = 4'd1, OP_POP = 4'd2, OP_CLEAR = 4'd3,
    OP_COUNT = 4'd4, OP_REVERSE = 4'd5, OP_LEN = 4'd6, OP_SET = 4'd7,
    OP_GET = 4'd8, OP_ERASE = 4'd9, OP_SWAP = 4'd10, OP_SORT = 4'd11
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INS_RD, ST_INS_WR, ST_CNT_RD, ST_CNT_CMP,
    ST_RV_A, ST_RV_B, ST_RV_C, ST_RV_D, ST_GET, ST_ER_RD, ST_ER_WR,
    ST_SO_KA, ST_SO_KB, ST_SO_CMP, ST_SO_PUT
  } state_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [31:0]      data;
  } mem_wr_t;

  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_res_t;
endpackage
`default_nettype wire

// ----- src/ile_store.sv -----
// Element store: one write port, one registered read port.
// Depends on ile_pkg.
`default_nettype none
module ile_store (
  input  wire logic                     clk,
  input  wire ile_pkg::mem_wr_t         wr,
  input  wire logic [ile_pkg::IDX_W-1:0] raddr,
  output logic [31:0]                   rdata
);
  logic [31:0] mem [ile_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- src/ile_cmp.sv -----
// Shared compare unit: equality and signed greater-than.
// Depends on ile_pkg.
`default_nettype none
module ile_cmp (
  input  wire logic [31:0]       a,
  input  wire logic [31:0]       b,
  output ile_pkg::cmp_res_t      res
);
  assign res.eq = (a == b);
  assign res.gt = ($signed(a) > $signed(b));
endmodule
`default_nettype wire

// ----- src/indexed_list_engine_top.sv -----
// Indexed list engine: sequencer, store and shared compare unit.
// Depends on ile_pkg, ile_store, ile_cmp.
//
// Takes one command per transfer while busy is low. Append, pop, clear, set,
// len and out-of-range get finish without leaving idle; get passes through a
// read state. Insert, erase and count walk the list one entry at a time,
// reverse and swap exchange entries pair by pair, and sort is an insertion
// sort that shifts one entry at a time, quadratic in the length. All of this
// is set by the single store port pair: one read and one write per cycle.
// Count, len and get produce one result, held on out_answer for one cycle
// with out_valid high; the receiver cannot stall it.
`default_nettype none
module indexed_list_engine_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [3:0]         in_operation,
  input  wire logic signed [15:0] in_position,
  input  wire logic signed [31:0] in_value,
  output logic                    out_valid,
  output logic signed [31:0]      out_answer
);
  localparam int IW = ile_pkg::IDX_W;
  localparam int CW = ile_pkg::CNT_W;
  localparam int MW = ile_pkg::CMP_W;

  ile_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] n_r, n_nxt, i_r, i_nxt, j_r, j_nxt, cnt_r, cnt_nxt;
  logic [31:0] opnd_r, opnd_nxt, tmp_r, tmp_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [31:0] out_answer_r, out_answer_nxt;

  ile_pkg::mem_wr_t wr;
  logic [IW-1:0] raddr;
  logic [31:0] rdata;
  ile_pkg::cmp_res_t cmp;

  logic accept;
  logic signed [MW-1:0] pos_ext, n_ext;
  logic in_range, ins_ok, swap_ok, full;
  logic [IW-1:0] p_idx;

  ile_store u_store (.clk(clk), .wr(wr), .raddr(raddr), .rdata(rdata));
  ile_cmp u_cmp (.a(rdata), .b(opnd_r), .res(cmp));

  assign busy = (state_r != ile_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign out_valid = out_valid_r;
  assign out_answer = out_answer_r;

  assign pos_ext = MW'(in_position);
  assign n_ext = $signed(MW'(n_r));
  assign full = (n_r == CW'(ile_pkg::CAPACITY));
  assign in_range = (pos_ext >= 0) && (pos_ext < n_ext);
  assign ins_ok = !full && (pos_ext >= 0) && (pos_ext <= n_ext);
  assign swap_ok = (pos_ext >= 0) && ((pos_ext + MW'(1)) < n_ext);
  assign p_idx = in_position[IW-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ile_pkg::ST_IDLE: begin
        if (accept) begin
          case (ile_pkg::op_t'(in_operation))
            ile_pkg::OP_INSERT:  if (ins_ok) state_nxt = ile_pkg::ST_INS_RD;
            ile_pkg::OP_COUNT:   state_nxt = ile_pkg::ST_CNT_RD;
            ile_pkg::OP_REVERSE: if (n_r > CW'(1)) state_nxt = ile_pkg::ST_RV_A;
            ile_pkg::OP_SWAP:    if (swap_ok) state_nxt = ile_pkg::ST_RV_A;
            ile_pkg::OP_GET:     if (in_range) state_nxt = ile_pkg::ST_GET;
            ile_pkg::OP_ERASE:   if (in_range) state_nxt = ile_pkg::ST_ER_RD;
            ile_pkg::OP_SORT:    state_nxt = ile_pkg::ST_SO_KA;
            default:             state_nxt = ile_pkg::ST_IDLE;
          endcase
        end
      end
      ile_pkg::ST_INS_RD:  state_nxt = (i_r == j_r) ? ile_pkg::ST_IDLE : ile_pkg::ST_INS_WR;
      ile_pkg::ST_INS_WR:  state_nxt = ile_pkg::ST_INS_RD;
      ile_pkg::ST_CNT_RD:  state_nxt = (i_r < n_r) ? ile_pkg::ST_CNT_CMP : ile_pkg::ST_IDLE;
      ile_pkg::ST_CNT_CMP: state_nxt = ile_pkg::ST_CNT_RD;
      ile_pkg::ST_RV_A:    state_nxt = ile_pkg::ST_RV_B;
      ile_pkg::ST_RV_B:    state_nxt = ile_pkg::ST_RV_C;
      ile_pkg::ST_RV_C:    state_nxt = ile_pkg::ST_RV_D;
      ile_pkg::ST_RV_D:
        state_nxt = ((i_r + CW'(2)) < j_r) ? ile_pkg::ST_RV_A : ile_pkg::ST_IDLE;
      ile_pkg::ST_GET:     state_nxt = ile_pkg::ST_IDLE;
      ile_pkg::ST_ER_RD:
        state_nxt = ((i_r + CW'(1)) < n_r) ? ile_pkg::ST_ER_WR : ile_pkg::ST_IDLE;
      ile_pkg::ST_ER_WR:   state_nxt = ile_pkg::ST_ER_RD;
      ile_pkg::ST_SO_KA:   state_nxt = (i_r < n_r) ? ile_pkg::ST_SO_KB : ile_pkg::ST_IDLE;
      ile_pkg::ST_SO_KB:   state_nxt = ile_pkg::ST_SO_CMP;
      ile_pkg::ST_SO_CMP: begin
        if (!cmp.gt) state_nxt = ile_pkg::ST_SO_KA;
        else if (j_r == CW'(1)) state_nxt = ile_pkg::ST_SO_PUT;
      end
      ile_pkg::ST_SO_PUT:  state_nxt = ile_pkg::ST_SO_KA;
      default:             state_nxt = ile_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    n_nxt = n_r;
    i_nxt = i_r;
    j_nxt = j_r;
    cnt_nxt = cnt_r;
    opnd_nxt = opnd_r;
    tmp_nxt = tmp_r;
    out_valid_nxt = 1'b0;
    out_answer_nxt = out_answer_r;
    wr = '0;
    raddr = i_r[IW-1:0];
    case (state_r)
      ile_pkg::ST_IDLE: begin
        if (accept) begin
          opnd_nxt = in_value;
          case (ile_pkg::op_t'(in_operation))
            ile_pkg::OP_APPEND: begin
              if (!full) begin
                wr = '{we: 1'b1, addr: n_r[IW-1:0], data: in_value};
                n_nxt = n_r + CW'(1);
              end
            end
            ile_pkg::OP_INSERT: begin
              i_nxt = n_r;
              j_nxt = CW'(p_idx);
            end
            ile_pkg::OP_POP:   if (n_r != '0) n_nxt = n_r - CW'(1);
            ile_pkg::OP_CLEAR: n_nxt = '0;
            ile_pkg::OP_COUNT: begin
              i_nxt = '0;
              cnt_nxt = '0;
            end
            ile_pkg::OP_REVERSE: begin
              i_nxt = '0;
              j_nxt = n_r - CW'(1);
            end
            ile_pkg::OP_LEN: begin
              out_valid_nxt = 1'b1;
              out_answer_nxt = 32'(n_r);
            end
            ile_pkg::OP_SET:
              if (in_range) wr = '{we: 1'b1, addr: p_idx, data: in_value};
            ile_pkg::OP_GET: begin
              raddr = p_idx;
              if (!in_range) begin
                out_valid_nxt = 1'b1;
                out_answer_nxt = '1;
              end
            end
            ile_pkg::OP_ERASE: i_nxt = CW'(p_idx);
            ile_pkg::OP_SWAP: begin
              i_nxt = CW'(p_idx);
              j_nxt = CW'(p_idx) + CW'(1);
            end
            ile_pkg::OP_SORT: i_nxt = CW'(1);
            default: ;
          endcase
        end
      end
      ile_pkg::ST_INS_RD: begin
        raddr = IW'(i_r - CW'(1));
        if (i_r == j_r) begin
          wr = '{we: 1'b1, addr: i_r[IW-1:0], data: opnd_r};
          n_nxt = n_r + CW'(1);
        end
      end
      ile_pkg::ST_INS_WR: begin
        wr = '{we: 1'b1, addr: i_r[IW-1:0], data: rdata};
        i_nxt = i_r - CW'(1);
      end
      ile_pkg::ST_CNT_RD: begin
        if (i_r >= n_r) begin
          out_valid_nxt = 1'b1;
          out_answer_nxt = 32'(cnt_r);
        end
      end
      ile_pkg::ST_CNT_CMP: begin
        if (cmp.eq) cnt_nxt = cnt_r + CW'(1);
        i_nxt = i_r + CW'(1);
      end
      ile_pkg::ST_RV_A: ;
      ile_pkg::ST_RV_B: begin
        tmp_nxt = rdata;
        raddr = j_r[IW-1:0];
      end
      ile_pkg::ST_RV_C: wr = '{we: 1'b1, addr: i_r[IW-1:0], data: rdata};
      ile_pkg::ST_RV_D: begin
        wr = '{we: 1'b1, addr: j_r[IW-1:0], data: tmp_r};
        i_nxt = i_r + CW'(1);
        j_nxt = j_r - CW'(1);
      end
      ile_pkg::ST_GET: begin
        out_valid_nxt = 1'b1;
        out_answer_nxt = rdata;
      end
      ile_pkg::ST_ER_RD: begin
        raddr = IW'(i_r + CW'(1));
        if ((i_r + CW'(1)) >= n_r) n_nxt = n_r - CW'(1);
      end
      ile_pkg::ST_ER_WR: begin
        wr = '{we: 1'b1, addr: i_r[IW-1:0], data: rdata};
        i_nxt = i_r + CW'(1);
      end
      ile_pkg::ST_SO_KA: ;
      ile_pkg::ST_SO_KB: begin
        opnd_nxt = rdata;
        j_nxt = i_r;
        raddr = IW'(i_r - CW'(1));
      end
      ile_pkg::ST_SO_CMP: begin
        if (cmp.gt) begin
          wr = '{we: 1'b1, addr: j_r[IW-1:0], data: rdata};
          j_nxt = j_r - CW'(1);
          raddr = IW'(j_r - CW'(2));
        end else begin
          wr = '{we: 1'b1, addr: j_r[IW-1:0], data: opnd_r};
          i_nxt = i_r + CW'(1);
        end
      end
      ile_pkg::ST_SO_PUT: begin
        wr = '{we: 1'b1, addr: '0, data: opnd_r};
        i_nxt = i_r + CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ile_pkg::ST_IDLE;
      n_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      n_r <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r <= i_nxt;
    j_r <= j_nxt;
    cnt_r <= cnt_nxt;
    opnd_r <= opnd_nxt;
    tmp_r <= tmp_nxt;
    out_answer_r <= out_answer_nxt;
  end

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CW'(ile_pkg::CAPACITY))
    else $error("length above capacity");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == ile_pkg::ST_IDLE
      || $past(state_r) == ile_pkg::ST_CNT_RD || $past(state_r) == ile_pkg::ST_GET))
    else $error("result strobe from a non-result state");

  a_len_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && state_r != ile_pkg::ST_INS_RD && state_r != ile_pkg::ST_ER_RD) |=> $stable(n_r))
    else $error("length changed mid-walk");

  a_sort_wr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ile_pkg::ST_SO_CMP && wr.we) |-> (CW'(wr.addr) < n_r))
    else $error("sort write outside list");
endmodule
`default_nettype wire
